@@ rtl/core/ets_pkg.sv @@
// Shared types, constants and the month length function for the epoch to calendar converter.
package ets_pkg;

  localparam int unsigned EPOCH_W  = 34;
  localparam int unsigned ZONE_W   = 17;
  localparam int unsigned REST_W   = 35;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;

  localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd19800;

  localparam logic [YEAR_W-1:0] BASE_YEAR     = 12'd1970;
  localparam logic [6:0]        BASE_MOD100   = 7'd70;
  localparam logic [8:0]        BASE_MOD400   = 9'd370;
  localparam logic [6:0]        MOD100_LAST   = 7'd99;
  localparam logic [8:0]        MOD400_LAST   = 9'd399;
  localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd12;

  localparam logic [REST_W-1:0] SECS_PER_MIN    = 35'd60;
  localparam logic [REST_W-1:0] SECS_PER_10MIN  = 35'd600;
  localparam logic [REST_W-1:0] SECS_PER_HOUR   = 35'd3600;
  localparam logic [REST_W-1:0] SECS_PER_DAY    = 35'd86400;
  localparam logic [REST_W-1:0] SECS_DAYS_28    = 35'd2419200;
  localparam logic [REST_W-1:0] SECS_DAYS_29    = 35'd2505600;
  localparam logic [REST_W-1:0] SECS_DAYS_30    = 35'd2592000;
  localparam logic [REST_W-1:0] SECS_DAYS_31    = 35'd2678400;
  localparam logic [REST_W-1:0] SECS_COMMON_YR  = 35'd31536000;
  localparam logic [REST_W-1:0] SECS_LEAP_YR    = 35'd31622400;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_YEAR   = 8'b0000_0010,
    ST_MONTH  = 8'b0000_0100,
    ST_DAY    = 8'b0000_1000,
    ST_HOUR   = 8'b0001_0000,
    ST_MIN10  = 8'b0010_0000,
    ST_MIN1   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  // Length of a month in seconds; month codes outside 1 to 12 mean nothing.
  function automatic logic [REST_W-1:0] month_secs(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
    logic [REST_W-1:0] secs;
    case (month) inside
      4'd2:                      secs = leap ? SECS_DAYS_29 : SECS_DAYS_28;
      4'd4, 4'd6, 4'd9, 4'd11:   secs = SECS_DAYS_30;
      default:                   secs = SECS_DAYS_31;
    endcase
    return secs;
  endfunction

endpackage

@@ rtl/core/ets_if.sv @@
// Valid/ready channel interfaces for timestamps in and calendar results out.
interface ets_in_if;
  logic                           valid;
  logic                           ready;
  logic [ets_pkg::EPOCH_W-1:0]    epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ets_out_if;
  logic                           valid;
  logic                           ready;
  logic [ets_pkg::YEAR_W-1:0]     cal_year;
  logic [ets_pkg::MONTH_W-1:0]    cal_month;
  logic [ets_pkg::DAY_W-1:0]      cal_day;
  logic [ets_pkg::HOUR_W-1:0]     cal_hour;
  logic [ets_pkg::MINUTE_W-1:0]   cal_minute;
  logic                           clamped;

  modport source (output valid, output cal_year, output cal_month, output cal_day,
                  output cal_hour, output cal_minute, output clamped, input ready);
  modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                  input cal_hour, input cal_minute, input clamped, output ready);
endinterface

@@ rtl/core/epoch_seconds_to_calendar.sv @@
// Converts step by step: whole years after 1970 are removed, then months, days, hours,
// ten-minute steps and minutes, each by one subtraction from the remaining seconds.
// All steps go through the single shared 36-bit subtract-and-compare unit, one step a cycle.
// Throughput: one timestamp per conversion, none taken before the last is handed over;
// a result left waiting in the output register holds only the next conversion, at its end.
// Reset (synchronous, rst_n low) empties the output and loads the zone offset with 19800.
module epoch_seconds_to_calendar (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic signed [ets_pkg::ZONE_W-1:0]   cfg_wr_data,
  ets_in_if.sink                              in_ch,
  ets_out_if.source                           out_ch
);

  // Control state.
  ets_pkg::state_t                   state_r, state_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [ets_pkg::ZONE_W-1:0] zone_r;

  // Working registers of the conversion.
  logic [ets_pkg::REST_W-1:0]   rest_r, rest_nxt;
  logic [ets_pkg::YEAR_W-1:0]   year_r, year_nxt;
  logic [6:0]                   mod100_r, mod100_nxt;
  logic [8:0]                   mod400_r, mod400_nxt;
  logic [ets_pkg::MONTH_W-1:0]  month_r, month_nxt;
  logic [ets_pkg::DAY_W-1:0]    day_r, day_nxt;
  logic [ets_pkg::HOUR_W-1:0]   hour_r, hour_nxt;
  logic [ets_pkg::MINUTE_W-1:0] minute_r, minute_nxt;
  logic                         clamp_r, clamp_nxt;

  // Output register, so that a finished result can wait while new work starts.
  logic [ets_pkg::YEAR_W-1:0]   o_year_r, o_year_nxt;
  logic [ets_pkg::MONTH_W-1:0]  o_month_r, o_month_nxt;
  logic [ets_pkg::DAY_W-1:0]    o_day_r, o_day_nxt;
  logic [ets_pkg::HOUR_W-1:0]   o_hour_r, o_hour_nxt;
  logic [ets_pkg::MINUTE_W-1:0] o_minute_r, o_minute_nxt;
  logic                         o_clamp_r, o_clamp_nxt;

  // Shared unit: one subtraction whose borrow doubles as the comparison.
  logic                          leap;
  logic [ets_pkg::REST_W-1:0]    sub_op;
  logic [ets_pkg::REST_W:0]      diff;
  logic                          fits;
  logic                          in_xfer;
  logic                          slot_free;
  logic signed [ets_pkg::REST_W:0] adj;

  // Gregorian rule: every 400th year, or every 4th year that is not a century.
  assign leap = (mod400_r == 9'd0) || ((year_r[1:0] == 2'b00) && (mod100_r != 7'd0));

  always_comb begin
    case (state_r)
      ets_pkg::ST_YEAR:  sub_op = leap ? ets_pkg::SECS_LEAP_YR : ets_pkg::SECS_COMMON_YR;
      ets_pkg::ST_MONTH: sub_op = ets_pkg::month_secs(month_r, leap);
      ets_pkg::ST_DAY:   sub_op = ets_pkg::SECS_PER_DAY;
      ets_pkg::ST_HOUR:  sub_op = ets_pkg::SECS_PER_HOUR;
      ets_pkg::ST_MIN10: sub_op = ets_pkg::SECS_PER_10MIN;
      default:           sub_op = ets_pkg::SECS_PER_MIN;
    endcase
  end

  assign diff = {1'b0, rest_r} - {1'b0, sub_op};
  assign fits = ~diff[ets_pkg::REST_W];

  // The timestamp is zero-extended and the offset sign-extended before the add.
  assign adj = $signed({2'b00, in_ch.epoch_seconds}) +
               (ets_pkg::REST_W + 1)'(zone_r);

  assign in_ch.ready = (state_r == ets_pkg::ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    rest_nxt      = rest_r;
    year_nxt      = year_r;
    mod100_nxt    = mod100_r;
    mod400_nxt    = mod400_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    clamp_nxt     = clamp_r;
    o_year_nxt    = o_year_r;
    o_month_nxt   = o_month_r;
    o_day_nxt     = o_day_r;
    o_hour_nxt    = o_hour_r;
    o_minute_nxt  = o_minute_r;
    o_clamp_nxt   = o_clamp_r;

    // A result leaves the output register when the sink takes the transfer.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ets_pkg::ST_IDLE: begin
        if (in_xfer) begin
          // A negative local time is pinned to the epoch itself and flagged.
          if (adj[ets_pkg::REST_W]) begin
            rest_nxt  = '0;
            clamp_nxt = 1'b1;
          end else begin
            rest_nxt  = adj[ets_pkg::REST_W-1:0];
            clamp_nxt = 1'b0;
          end
          year_nxt   = ets_pkg::BASE_YEAR;
          mod100_nxt = ets_pkg::BASE_MOD100;
          mod400_nxt = ets_pkg::BASE_MOD400;
          month_nxt  = ets_pkg::MONTH_W'(1);
          day_nxt    = ets_pkg::DAY_W'(1);
          hour_nxt   = '0;
          minute_nxt = '0;
          state_nxt  = ets_pkg::ST_YEAR;
        end
      end
      ets_pkg::ST_YEAR: begin
        // Whole years are removed one by one; the modulo counters follow the year
        // so that the leap rule never needs a divider.
        if (fits) begin
          rest_nxt   = diff[ets_pkg::REST_W-1:0];
          year_nxt   = year_r + 1'b1;
          mod100_nxt = (mod100_r == ets_pkg::MOD100_LAST) ? 7'd0 : mod100_r + 1'b1;
          mod400_nxt = (mod400_r == ets_pkg::MOD400_LAST) ? 9'd0 : mod400_r + 1'b1;
        end else begin
          state_nxt = ets_pkg::ST_MONTH;
        end
      end
      ets_pkg::ST_MONTH: begin
        // December is never removed, whatever remains.
        if (fits && (month_r != ets_pkg::LAST_MONTH)) begin
          rest_nxt  = diff[ets_pkg::REST_W-1:0];
          month_nxt = month_r + 1'b1;
        end else begin
          state_nxt = ets_pkg::ST_DAY;
        end
      end
      ets_pkg::ST_DAY: begin
        if (fits) begin
          rest_nxt = diff[ets_pkg::REST_W-1:0];
          day_nxt  = day_r + 1'b1;
        end else begin
          state_nxt = ets_pkg::ST_HOUR;
        end
      end
      ets_pkg::ST_HOUR: begin
        // Years and months are whole days, so the remainder holds the time of day.
        if (fits) begin
          rest_nxt = diff[ets_pkg::REST_W-1:0];
          hour_nxt = hour_r + 1'b1;
        end else begin
          state_nxt = ets_pkg::ST_MIN10;
        end
      end
      ets_pkg::ST_MIN10: begin
        if (fits) begin
          rest_nxt   = diff[ets_pkg::REST_W-1:0];
          minute_nxt = minute_r + ets_pkg::MINUTE_W'(10);
        end else begin
          state_nxt = ets_pkg::ST_MIN1;
        end
      end
      ets_pkg::ST_MIN1: begin
        if (fits) begin
          rest_nxt   = diff[ets_pkg::REST_W-1:0];
          minute_nxt = minute_r + 1'b1;
        end else begin
          state_nxt = ets_pkg::ST_FINISH;
        end
      end
      ets_pkg::ST_FINISH: begin
        // Hand the result over as soon as the output register is free.
        if (slot_free) begin
          o_year_nxt    = year_r;
          o_month_nxt   = month_r;
          o_day_nxt     = day_r;
          o_hour_nxt    = hour_r;
          o_minute_nxt  = minute_r;
          o_clamp_nxt   = clamp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ets_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ets_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ets_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      zone_r      <= ets_pkg::ZONE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        zone_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    year_r     <= year_nxt;
    mod100_r   <= mod100_nxt;
    mod400_r   <= mod400_nxt;
    month_r    <= month_nxt;
    day_r      <= day_nxt;
    hour_r     <= hour_nxt;
    minute_r   <= minute_nxt;
    clamp_r    <= clamp_nxt;
    o_year_r   <= o_year_nxt;
    o_month_r  <= o_month_nxt;
    o_day_r    <= o_day_nxt;
    o_hour_r   <= o_hour_nxt;
    o_minute_r <= o_minute_nxt;
    o_clamp_r  <= o_clamp_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cal_year   = o_year_r;
  assign out_ch.cal_month  = o_month_r;
  assign out_ch.cal_day    = o_day_r;
  assign out_ch.cal_hour   = o_hour_r;
  assign out_ch.cal_minute = o_minute_r;
  assign out_ch.clamped    = o_clamp_r;

endmodule
